// ===== rtl/mcdt_pkg.sv =====
`timescale 1ns / 1ps

package mcdt_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_CHANNELS = 9;
    localparam int DEF_NUM_PERIODIC = 3;
    localparam int DEF_TIME_BITS    = 48;

    // Field widths fixed by the interface
    localparam int CMD_W  = 2;
    localparam int CHAN_W = 4;
    localparam int DLY_W  = 16;
    localparam int WAIT_W = 16;

    // Period registers
    localparam int NUM_REGS  = 3;
    localparam int REG_W     = 16;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_W-1:0] PERIOD_RESET = 16'd1000;

    typedef logic [REG_W-1:0] period_t;
    typedef period_t [NUM_REGS-1:0] period_arr_t;

    // Microseconds per millisecond; a 16-bit ms count times this fits in 26 bits
    localparam int US_PER_MS   = 1000;
    localparam int PERIOD_US_W = 26;

    // Remainder unit: dividend bits retired per cycle
    localparam int RADIX_BITS = 4;

    // Front-to-back queue depth
    localparam int QUEUE_DEPTH = 2;

    // us -> ms conversion: floor(x * RECIP / 2^RECIP_SHIFT) is floor(x/1000) or one less
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP = 27'd68719476;
    localparam int PROD_W      = PERIOD_US_W + RECIP_W;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;
    localparam int SAT_LIMIT_US = 65536000;
    localparam logic [WAIT_W-1:0] WAIT_MAX = 16'hFFFF;
    localparam logic [WAIT_W-1:0] WAIT_MIN = 16'd1;

    // Input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE = 2'd0,
        CMD_ARM    = 2'd1,
        CMD_DISARM = 2'd2,
        CMD_LOAD   = 2'd3
    } cmd_t;

    // Classified operation handed to the back end
    localparam int OP_W = 2;
    typedef enum logic [OP_W-1:0] {
        OP_NONE   = 2'd0,
        OP_ARM    = 2'd1,
        OP_DISARM = 2'd2,
        OP_LOAD   = 2'd3
    } op_t;

    // Back-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_REM,
        ST_MUL,
        ST_CORR
    } state_t;

endpackage

// ===== rtl/mcdt_fifo.sv =====
`timescale 1ns / 1ps

module mcdt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mcdt_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/mcdt_front.sv =====
`timescale 1ns / 1ps

module mcdt_front #(
    parameter int NUM_CHANNELS = mcdt_pkg::DEF_NUM_CHANNELS,
    parameter int NUM_PERIODIC = mcdt_pkg::DEF_NUM_PERIODIC,
    parameter int TIME_BITS    = mcdt_pkg::DEF_TIME_BITS,
    parameter int ITEM_W       = mcdt_pkg::OP_W + $clog2(NUM_CHANNELS) + 2 * TIME_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mcdt_pkg::CMD_W-1:0]  s_cmd,
    input  logic [TIME_BITS-1:0]        s_now_us,
    input  logic [mcdt_pkg::CHAN_W-1:0] s_channel,
    input  logic [mcdt_pkg::DLY_W-1:0]  s_delay_ms,
    input  logic [TIME_BITS-1:0]        s_deadline_us,
    output logic                        item_valid,
    input  logic                        item_ready,
    output logic [ITEM_W-1:0]           item_data
);

    localparam int CH_W = $clog2(NUM_CHANNELS);
    localparam int PW   = mcdt_pkg::PERIOD_US_W;

    logic                   vld_reg, vld_next;
    logic [ITEM_W-1:0]      item_reg;
    logic                   in_range, oneshot, take;
    mcdt_pkg::op_t          op;
    logic [PW-1:0]          dly_us;
    logic [TIME_BITS-1:0]   value;

    assign take     = s_valid && s_ready;
    assign s_ready  = !vld_reg || item_ready;
    assign in_range = int'(s_channel) < NUM_CHANNELS;
    assign oneshot  = int'(s_channel) >= NUM_PERIODIC;
    assign dly_us   = PW'(s_delay_ms) * PW'(mcdt_pkg::US_PER_MS);

    // Range and channel-kind checks; arm-if-idle is left to the back end
    always_comb begin
        op    = mcdt_pkg::OP_NONE;
        value = s_deadline_us;
        case (mcdt_pkg::cmd_t'(s_cmd))
            mcdt_pkg::CMD_UPDATE: op = mcdt_pkg::OP_NONE;
            mcdt_pkg::CMD_ARM: begin
                value = s_now_us + TIME_BITS'(dly_us);
                if (in_range && oneshot) op = mcdt_pkg::OP_ARM;
            end
            mcdt_pkg::CMD_DISARM: begin
                if (in_range && oneshot) op = mcdt_pkg::OP_DISARM;
            end
            mcdt_pkg::CMD_LOAD: begin
                if (in_range) op = mcdt_pkg::OP_LOAD;
            end
            default: op = mcdt_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (item_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= {op, CH_W'(s_channel), s_now_us, value};
        end
    end

    assign item_valid = vld_reg;
    assign item_data  = item_reg;

endmodule

// ===== rtl/mcdt_rem.sv =====
`timescale 1ns / 1ps

module mcdt_rem #(
    parameter int TIME_BITS = mcdt_pkg::DEF_TIME_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [TIME_BITS-1:0]             dividend,
    input  logic [mcdt_pkg::PERIOD_US_W-1:0] divisor,
    output logic                             done,
    output logic [mcdt_pkg::PERIOD_US_W-1:0] remainder
);

    localparam int RB    = mcdt_pkg::RADIX_BITS;
    localparam int PW    = mcdt_pkg::PERIOD_US_W;
    localparam int ITERS = (TIME_BITS + RB - 1) / RB;
    localparam int DW    = ITERS * RB;
    localparam int CNT_W = $clog2(ITERS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    sh_reg, sh_next;
    logic [PW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    div_reg, div_next;
    logic [PW-1:0]    step_rem;

    // Restoring remainder, RB dividend bits per cycle
    always_comb begin
        logic [PW:0] trial;
        step_rem = rem_reg;
        for (int i = 0; i < RB; i++) begin
            trial = {step_rem, sh_reg[DW-1-i]};
            if (trial >= {1'b0, div_reg}) begin
                step_rem = PW'(trial - {1'b0, div_reg});
            end else begin
                step_rem = PW'(trial);
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ITERS);
            sh_next   = DW'(dividend);
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            sh_next  = sh_reg << RB;
            rem_next = step_rem;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/mcdt_back.sv =====
`timescale 1ns / 1ps

module mcdt_back #(
    parameter int NUM_CHANNELS = mcdt_pkg::DEF_NUM_CHANNELS,
    parameter int NUM_PERIODIC = mcdt_pkg::DEF_NUM_PERIODIC,
    parameter int TIME_BITS    = mcdt_pkg::DEF_TIME_BITS,
    parameter int ITEM_W       = mcdt_pkg::OP_W + $clog2(NUM_CHANNELS) + 2 * TIME_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mcdt_pkg::period_arr_t       periods,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [ITEM_W-1:0]           item_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [NUM_CHANNELS-1:0]     m_fired_mask,
    output logic [mcdt_pkg::WAIT_W-1:0] m_wait_ms
);

    localparam int CH_W = $clog2(NUM_CHANNELS);
    localparam int PW   = mcdt_pkg::PERIOD_US_W;
    localparam int QW   = mcdt_pkg::Q_W;
    localparam int WW   = mcdt_pkg::WAIT_W;
    localparam logic [NUM_CHANNELS-1:0] PER_MASK =
        NUM_CHANNELS'((64'd1 << NUM_PERIODIC) - 64'd1);

    mcdt_pkg::state_t state_reg, state_next;

    mcdt_pkg::op_t          op_reg, op_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [TIME_BITS-1:0]   val_reg, val_next;

    logic [TIME_BITS-1:0]   deadline_reg [NUM_CHANNELS];
    logic [TIME_BITS-1:0]   deadline_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] armed_reg, armed_next;

    logic [CH_W-1:0]         idx_reg, idx_next;
    logic [TIME_BITS-1:0]    best_reg, best_next;
    logic [NUM_CHANNELS-1:0] fired_reg, fired_next;
    logic [PW-1:0]           p_reg, p_next;
    logic [mcdt_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                    sat_reg, sat_next;

    logic                    out_valid_reg, out_valid_next;
    logic [NUM_CHANNELS-1:0] out_mask_reg, out_mask_next;
    logic [WW-1:0]           out_wait_reg, out_wait_next;

    // Scan datapath
    logic [TIME_BITS-1:0] cur_dl, diff, behind, new_dl, off_t;
    logic                 late, is_per, active, last;
    logic [mcdt_pkg::REG_W-1:0] p_ms;
    logic [PW-1:0]        p_us, off;

    // Conversion datapath
    logic [QW-1:0] q0, q;
    logic [PW-1:0] rmd;
    logic [WW-1:0] wait_val;

    // Sequencer outputs
    logic q_pop, rem_start, res_load;
    logic rem_done;
    logic [PW-1:0] rem_val;

    assign cur_dl = deadline_reg[idx_reg];
    assign diff   = cur_dl - now_reg;
    assign behind = now_reg - cur_dl;
    assign late   = diff[TIME_BITS-1];
    assign is_per = PER_MASK[idx_reg];
    assign active = is_per || armed_reg[idx_reg];
    assign last   = (idx_reg == CH_W'(NUM_CHANNELS - 1));

    // Period of the scanned channel; zero counts as 1 ms
    always_comb begin
        p_ms = '0;
        if (int'(idx_reg) < mcdt_pkg::NUM_REGS) begin
            p_ms = periods[idx_reg[mcdt_pkg::REG_IDX_W-1:0]];
        end
        if (p_ms == '0) begin
            p_ms = mcdt_pkg::REG_W'(1);
        end
    end
    assign p_us = PW'(p_ms) * PW'(mcdt_pkg::US_PER_MS);

    // Catch-up: new deadline sits (p - r) mod p past now, r = (now - deadline) mod p
    assign off    = (rem_val == '0) ? '0 : p_reg - rem_val;
    assign off_t  = TIME_BITS'(off);
    assign new_dl = now_reg + off_t;

    // us -> ms with one correction step
    assign q0  = prod_reg[mcdt_pkg::RECIP_SHIFT +: QW];
    assign rmd = best_reg[PW-1:0] - PW'(q0) * PW'(mcdt_pkg::US_PER_MS);
    assign q   = (rmd >= PW'(mcdt_pkg::US_PER_MS)) ? q0 + 1'b1 : q0;
    always_comb begin
        if (sat_reg) begin
            wait_val = mcdt_pkg::WAIT_MAX;
        end else if (q == '0) begin
            wait_val = mcdt_pkg::WAIT_MIN;
        end else begin
            wait_val = WW'(q);
        end
    end

    mcdt_rem #(
        .TIME_BITS (TIME_BITS)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (behind),
        .divisor   (p_us),
        .done      (rem_done),
        .remainder (rem_val)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcdt_pkg::ST_IDLE: begin
                if (item_valid) state_next = mcdt_pkg::ST_APPLY;
            end
            mcdt_pkg::ST_APPLY: state_next = mcdt_pkg::ST_SCAN;
            mcdt_pkg::ST_SCAN: begin
                if (active && late && is_per) begin
                    state_next = mcdt_pkg::ST_REM;
                end else if (last) begin
                    state_next = mcdt_pkg::ST_MUL;
                end
            end
            mcdt_pkg::ST_REM: begin
                if (rem_done) begin
                    state_next = last ? mcdt_pkg::ST_MUL : mcdt_pkg::ST_SCAN;
                end
            end
            mcdt_pkg::ST_MUL: state_next = mcdt_pkg::ST_CORR;
            mcdt_pkg::ST_CORR: begin
                if (!out_valid_reg || m_ready) state_next = mcdt_pkg::ST_IDLE;
            end
            default: state_next = mcdt_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        q_pop     = 1'b0;
        rem_start = 1'b0;
        res_load  = 1'b0;
        case (state_reg)
            mcdt_pkg::ST_IDLE: q_pop     = item_valid;
            mcdt_pkg::ST_SCAN: rem_start = active && late && is_per;
            mcdt_pkg::ST_CORR: res_load  = !out_valid_reg || m_ready;
            default: begin
                q_pop     = 1'b0;
                rem_start = 1'b0;
                res_load  = 1'b0;
            end
        endcase
    end

    // Datapath
    always_comb begin
        op_next        = op_reg;
        ch_next        = ch_reg;
        now_next       = now_reg;
        val_next       = val_reg;
        deadline_next  = deadline_reg;
        armed_next     = armed_reg;
        idx_next       = idx_reg;
        best_next      = best_reg;
        fired_next     = fired_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        out_mask_next  = out_mask_reg;
        out_wait_next  = out_wait_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            mcdt_pkg::ST_IDLE: begin
                if (q_pop) begin
                    op_next  = mcdt_pkg::op_t'(item_data[ITEM_W-1 -: mcdt_pkg::OP_W]);
                    ch_next  = item_data[2*TIME_BITS +: CH_W];
                    now_next = item_data[TIME_BITS +: TIME_BITS];
                    val_next = item_data[TIME_BITS-1:0];
                end
            end
            mcdt_pkg::ST_APPLY: begin
                case (op_reg)
                    mcdt_pkg::OP_ARM: begin
                        if (!armed_reg[ch_reg]) begin
                            deadline_next[ch_reg] = val_reg;
                            armed_next[ch_reg]    = 1'b1;
                        end
                    end
                    mcdt_pkg::OP_DISARM: armed_next[ch_reg] = 1'b0;
                    mcdt_pkg::OP_LOAD: begin
                        deadline_next[ch_reg] = val_reg;
                        armed_next[ch_reg]    = 1'b1;
                    end
                    default: armed_next = armed_reg;
                endcase
                idx_next   = '0;
                best_next  = '1;
                fired_next = '0;
            end
            mcdt_pkg::ST_SCAN: begin
                if (active) begin
                    if (late) begin
                        fired_next[idx_reg] = 1'b1;
                        if (is_per) begin
                            p_next = p_us;
                        end else begin
                            armed_next[idx_reg] = 1'b0;
                        end
                    end else if (diff < best_reg) begin
                        best_next = diff;
                    end
                end
                if (!rem_start && !last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            mcdt_pkg::ST_REM: begin
                if (rem_done) begin
                    deadline_next[idx_reg] = new_dl;
                    if (off_t < best_reg) best_next = off_t;
                    if (!last) idx_next = idx_reg + 1'b1;
                end
            end
            mcdt_pkg::ST_MUL: begin
                sat_next  = best_reg >= TIME_BITS'(mcdt_pkg::SAT_LIMIT_US);
                prod_next = mcdt_pkg::PROD_W'(best_reg[PW-1:0])
                          * mcdt_pkg::PROD_W'(mcdt_pkg::RECIP);
            end
            mcdt_pkg::ST_CORR: begin
                if (res_load) begin
                    out_valid_next = 1'b1;
                    out_mask_next  = fired_reg;
                    out_wait_next  = wait_val;
                end
            end
            default: idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mcdt_pkg::ST_IDLE;
            armed_reg     <= PER_MASK;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                deadline_reg[c] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
            deadline_reg  <= deadline_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        now_reg      <= now_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        fired_reg    <= fired_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        sat_reg      <= sat_next;
        out_mask_reg <= out_mask_next;
        out_wait_reg <= out_wait_next;
    end

    assign item_ready   = q_pop;
    assign m_valid      = out_valid_reg;
    assign m_fired_mask = out_mask_reg;
    assign m_wait_ms    = out_wait_reg;

endmodule

// ===== rtl/multi_channel_deadline_timer_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                                         Direction
// --------  --------------------------------------------  ---------
// input     s_valid s_ready s_cmd s_now_us s_channel       in
//           s_delay_ms s_deadline_us
// result    m_valid m_ready m_fired_mask m_wait_ms         out
// config    cfg_valid cfg_ready cfg_index cfg_data         in
//
// Scan: one channel per cycle, pausing at each periodic channel that must catch up
//   while the 4-bit-per-cycle remainder unit works out its new deadline.
// Reset: synchronous, active low. Deadlines clear to zero, periodic channels armed,
//   one-shot channels idle, period registers at 1000 ms.
// Stalls: a front register and a two-word queue take input words while the back end
//   is busy; a finished result waits in the output register while the next word runs.
// Config writes are always accepted; indexes past the last register are dropped.

module multi_channel_deadline_timer_core #(
    parameter int NUM_CHANNELS = mcdt_pkg::DEF_NUM_CHANNELS,
    parameter int NUM_PERIODIC = mcdt_pkg::DEF_NUM_PERIODIC,
    parameter int TIME_BITS    = mcdt_pkg::DEF_TIME_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input words
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mcdt_pkg::CMD_W-1:0]     s_cmd,
    input  logic [TIME_BITS-1:0]           s_now_us,
    input  logic [mcdt_pkg::CHAN_W-1:0]    s_channel,
    input  logic [mcdt_pkg::DLY_W-1:0]     s_delay_ms,
    input  logic [TIME_BITS-1:0]           s_deadline_us,
    // result words
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [NUM_CHANNELS-1:0]        m_fired_mask,
    output logic [mcdt_pkg::WAIT_W-1:0]    m_wait_ms,
    // period register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mcdt_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [mcdt_pkg::REG_W-1:0]     cfg_data
);

    // queue word: {op, channel, now, deadline-to-write}
    localparam int ITEM_W = mcdt_pkg::OP_W + $clog2(NUM_CHANNELS) + 2 * TIME_BITS;

    mcdt_pkg::period_arr_t period_reg, period_next;

    logic              fe_valid, fe_ready;
    logic [ITEM_W-1:0] fe_data;
    logic              be_valid, be_ready;
    logic [ITEM_W-1:0] be_data;

    // Period registers
    assign cfg_ready = 1'b1;

    always_comb begin
        period_next = period_reg;
        if (cfg_valid && cfg_ready
            && cfg_index < mcdt_pkg::REG_IDX_W'(mcdt_pkg::NUM_REGS)) begin
            period_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < mcdt_pkg::NUM_REGS; r++) begin
                period_reg[r] <= mcdt_pkg::PERIOD_RESET;
            end
        end else begin
            period_reg <= period_next;
        end
    end

    // Front end: decode, range check, arm deadline
    mcdt_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_PERIODIC (NUM_PERIODIC),
        .TIME_BITS    (TIME_BITS),
        .ITEM_W       (ITEM_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_now_us      (s_now_us),
        .s_channel     (s_channel),
        .s_delay_ms    (s_delay_ms),
        .s_deadline_us (s_deadline_us),
        .item_valid    (fe_valid),
        .item_ready    (fe_ready),
        .item_data     (fe_data)
    );

    // Decoupling queue
    mcdt_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (mcdt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_data),
        .pop_valid  (be_valid),
        .pop_ready  (be_ready),
        .pop_data   (be_data)
    );

    // Back end: command apply, channel scan, catch-up, ms conversion
    mcdt_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_PERIODIC (NUM_PERIODIC),
        .TIME_BITS    (TIME_BITS),
        .ITEM_W       (ITEM_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .periods      (period_reg),
        .item_valid   (be_valid),
        .item_ready   (be_ready),
        .item_data    (be_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fired_mask (m_fired_mask),
        .m_wait_ms    (m_wait_ms)
    );

endmodule

// ===== verif/tb_multi_channel_deadline_timer_core.sv =====
`timescale 1ns / 1ps

module tb_multi_channel_deadline_timer_core;

    localparam int NCH = mcdt_pkg::DEF_NUM_CHANNELS;
    localparam int NPER = mcdt_pkg::DEF_NUM_PERIODIC;
    localparam int TB = mcdt_pkg::DEF_TIME_BITS;

    // Receiver hold-off used to back the block up into its input queue
    localparam int LONG_HOLD = 600;
    // Idle cycles after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 64;
    // Cycles with no word moving on any channel before the run is called hung
    localparam int STALL_LIMIT = 4000;
    localparam int WORDS_PER_PHASE = 366;
    localparam int NUM_PHASES = 5;

    typedef struct packed {
        mcdt_pkg::cmd_t                 cmd;
        logic [TB-1:0]                  now_us;
        logic [mcdt_pkg::CHAN_W-1:0]    channel;
        logic [mcdt_pkg::DLY_W-1:0]     delay_ms;
        logic [TB-1:0]                  deadline_us;
    } cmd_word_t;

    typedef struct packed {
        logic [NCH-1:0]                 fired_mask;
        logic [mcdt_pkg::WAIT_W-1:0]    wait_ms;
    } timer_result_t;

    // Tracks deadlines, armed bits and period registers; queues the result each
    // accepted command word must produce and checks result words against it.
    class deadline_tracker;
        logic [TB-1:0]      dl_us [NCH];
        logic [NCH-1:0]     armed;
        mcdt_pkg::period_t  period [mcdt_pkg::NUM_REGS];
        timer_result_t      due_q [$];
        int unsigned        mismatches;
        int unsigned        words;
        int unsigned        catchups;
        int unsigned        expiries;
        int unsigned        saturated;

        function new();
            for (int c = 0; c < NCH; c++) dl_us[c] = '0;
            armed = '0;
            for (int c = 0; c < NPER; c++) armed[c] = 1'b1;
            for (int r = 0; r < mcdt_pkg::NUM_REGS; r++) period[r] = mcdt_pkg::PERIOD_RESET;
            mismatches = 0;
            words = 0;
            catchups = 0;
            expiries = 0;
            saturated = 0;
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        function void write_period(logic [mcdt_pkg::REG_IDX_W-1:0] idx,
                                   mcdt_pkg::period_t val);
            if (int'(idx) < mcdt_pkg::NUM_REGS) period[idx] = val;
        endfunction

        function void note_word(mcdt_pkg::cmd_t cmd, logic [TB-1:0] now,
                                logic [mcdt_pkg::CHAN_W-1:0] chan,
                                logic [mcdt_pkg::DLY_W-1:0] dly, logic [TB-1:0] dl);
            timer_result_t      res;
            logic [TB-1:0]      diff;
            logic [TB-1:0]      late;
            longint unsigned    p_us;
            longint unsigned    steps;
            longint unsigned    best_us;
            longint unsigned    ms;
            bit                 one_shot;

            words++;
            // command first, then the scan
            if (int'(chan) < NCH) begin
                one_shot = int'(chan) >= NPER;
                if (cmd == mcdt_pkg::CMD_ARM && one_shot && !armed[chan]) begin
                    dl_us[chan] = now + TB'(dly) * TB'(mcdt_pkg::US_PER_MS);
                    armed[chan] = 1'b1;
                end else if (cmd == mcdt_pkg::CMD_DISARM && one_shot) begin
                    armed[chan] = 1'b0;
                end else if (cmd == mcdt_pkg::CMD_LOAD) begin
                    dl_us[chan] = dl;
                    armed[chan] = 1'b1;
                end
            end

            res.fired_mask = '0;
            best_us = '1;
            for (int c = 0; c < NCH; c++) begin
                if (c >= NPER && !armed[c]) continue;
                diff = dl_us[c] - now;
                if (diff[TB-1]) begin
                    res.fired_mask[c] = 1'b1;
                    if (c < NPER) begin
                        // jump ahead by whole periods; a zero period counts as 1 ms
                        p_us = (period[c] == '0) ? 64'd1 : 64'(period[c]);
                        p_us = p_us * mcdt_pkg::US_PER_MS;
                        late = now - dl_us[c];
                        steps = (64'(late) + p_us - 1) / p_us;
                        dl_us[c] = dl_us[c] + TB'(steps * p_us);
                        diff = dl_us[c] - now;
                        catchups++;
                    end else begin
                        armed[c] = 1'b0;
                        expiries++;
                        continue;
                    end
                end
                if (64'(diff) < best_us) best_us = 64'(diff);
            end

            ms = best_us / mcdt_pkg::US_PER_MS;
            if (ms == 0) ms = 1;
            if (ms > 64'(mcdt_pkg::WAIT_MAX)) begin
                ms = 64'(mcdt_pkg::WAIT_MAX);
                saturated++;
            end
            res.wait_ms = mcdt_pkg::WAIT_W'(ms);
            due_q.push_back(res);
        endfunction

        task check_word(logic [NCH-1:0] fired, logic [mcdt_pkg::WAIT_W-1:0] wt);
            timer_result_t want;
            if (due_q.size() == 0) begin
                flag_mismatch($sformatf("result word fired=%h wait=%0d with nothing pending",
                                        fired, wt));
                return;
            end
            want = due_q.pop_front();
            if (fired !== want.fired_mask)
                flag_mismatch($sformatf("fired_mask %h, predicted %h", fired, want.fired_mask));
            if (wt !== want.wait_ms)
                flag_mismatch($sformatf("wait_ms %0d, predicted %0d", wt, want.wait_ms));
        endtask
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [mcdt_pkg::CMD_W-1:0]         s_cmd;
    logic [TB-1:0]                      s_now_us;
    logic [mcdt_pkg::CHAN_W-1:0]        s_channel;
    logic [mcdt_pkg::DLY_W-1:0]         s_delay_ms;
    logic [TB-1:0]                      s_deadline_us;
    logic                               m_valid;
    logic                               m_ready;
    logic [NCH-1:0]                     m_fired_mask;
    logic [mcdt_pkg::WAIT_W-1:0]        m_wait_ms;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [mcdt_pkg::REG_IDX_W-1:0]     cfg_index;
    logic [mcdt_pkg::REG_W-1:0]         cfg_data;

    deadline_tracker tracker = new();

    // Time base that the random words mostly follow; roll_word updates it
    logic [TB-1:0] clock_us;
    // Receiver modes, set by the main sequence
    bit steady;
    bit long_hold_req;

    multi_channel_deadline_timer_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Monitor: every channel is sampled at the rising edge. A result word
    // is checked before the same edge's command word is queued; latency
    // keeps the two from belonging to the same command anyway.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) tracker.check_word(m_fired_mask, m_wait_ms);
            if (s_valid && s_ready)
                tracker.note_word(mcdt_pkg::cmd_t'(s_cmd), s_now_us, s_channel, s_delay_ms,
                                  s_deadline_us);
            if (cfg_valid && cfg_ready) tracker.write_period(cfg_index, cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // Result sink: alternating ready and stall runs of random length, an
    // always-ready mode, and one long hold-off counted here so the block
    // backs up and drops s_ready while the sender keeps offering.
    // ------------------------------------------------------------------
    initial begin : result_sink
        bit          ready_run;
        int unsigned left;
        m_ready = 1'b0;
        ready_run = 1'b0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                long_hold_req = 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                if (left == 0) begin
                    ready_run = !ready_run;
                    left = ready_run ? $urandom_range(1, 20) : $urandom_range(1, 8);
                end
                m_ready <= ready_run;
                left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any word moving on any channel resets the count.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (aresetn === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("[multi_channel_deadline_timer_core] ERROR");
        $finish;
    end

    // Offer one command word; valid stays up and the payload holds until taken.
    task automatic send_word(input cmd_word_t w);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_cmd         <= w.cmd;
        s_now_us      <= w.now_us;
        s_channel     <= w.channel;
        s_delay_ms    <= w.delay_ms;
        s_deadline_us <= w.deadline_us;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic sender_rest(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic settle();
        sender_rest(1);
        while (tracker.due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mcdt_pkg::REG_IDX_W-1:0] idx,
                             input mcdt_pkg::period_t val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic cmd_word_t mk(mcdt_pkg::cmd_t cmd, logic [TB-1:0] now,
                                     logic [mcdt_pkg::CHAN_W-1:0] chan,
                                     logic [mcdt_pkg::DLY_W-1:0] dly, logic [TB-1:0] dl);
        cmd_word_t w;
        w.cmd = cmd;
        w.now_us = now;
        w.channel = chan;
        w.delay_ms = dly;
        w.deadline_us = dl;
        return w;
    endfunction

    // Random word: time mostly creeps forward so periodic and one-shot
    // deadlines really expire; now and then it leaps anywhere, or to just
    // below the wrap point.
    function automatic cmd_word_t roll_word();
        cmd_word_t   w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            clock_us = TB'({$urandom(), $urandom()});
        else if (pick < 4)
            clock_us = '1 - TB'($urandom_range(0, 3000000));
        else if (pick < 14)
            clock_us = clock_us + TB'($urandom_range(0, 50000000));
        else if (pick < 64)
            clock_us = clock_us + TB'($urandom_range(0, 400000));
        w.now_us = clock_us;

        pick = $urandom_range(0, 99);
        w.cmd = (pick < 40) ? mcdt_pkg::CMD_UPDATE : (pick < 65) ? mcdt_pkg::CMD_ARM :
                (pick < 80) ? mcdt_pkg::CMD_DISARM : mcdt_pkg::CMD_LOAD;

        pick = $urandom_range(0, 99);
        if (pick < 70)      w.channel = mcdt_pkg::CHAN_W'($urandom_range(NPER, NCH - 1));
        else if (pick < 88) w.channel = mcdt_pkg::CHAN_W'($urandom_range(0, NPER - 1));
        else                w.channel = mcdt_pkg::CHAN_W'($urandom_range(NCH, 15));

        w.delay_ms = ($urandom_range(0, 99) < 85) ? mcdt_pkg::DLY_W'($urandom_range(0, 2500))
                                                  : mcdt_pkg::DLY_W'($urandom());

        pick = $urandom_range(0, 99);
        if (pick < 70)      w.deadline_us = clock_us + TB'($urandom_range(0, 3000000));
        else if (pick < 85) w.deadline_us = clock_us - TB'($urandom_range(0, 2000000));
        else                w.deadline_us = TB'({$urandom(), $urandom()});
        return w;
    endfunction

    // One random stretch: bursts with random gaps, or one unbroken run when
    // steady; optionally a long receiver hold-off halfway through.
    task automatic run_phase(input int unsigned count, input bit with_hold);
        int unsigned sent;
        int unsigned burst;
        bit          held;
        sent = 0;
        held = 1'b0;
        while (sent < count) begin
            burst = steady ? count : $urandom_range(1, 16);
            if (with_hold && !held && sent >= count / 2) begin
                long_hold_req = 1'b1;
                held = 1'b1;
                burst = 40;
            end
            for (int i = 0; i < burst && sent < count; i++) begin
                send_word(roll_word());
                sent++;
            end
            if (!steady) sender_rest($urandom_range(1, 24));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        mcdt_pkg::period_t setting [NUM_PHASES][mcdt_pkg::NUM_REGS];

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_cmd         = '0;
        s_now_us      = '0;
        s_channel     = '0;
        s_delay_ms    = '0;
        s_deadline_us = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        steady        = 1'b0;
        long_hold_req = 1'b0;
        clock_us      = '0;

        // Period sets: extremes, a zero period (runs as 1 ms), a random set, a mixed set, all 1 ms
        setting[0] = '{16'd1, 16'd65535, 16'd500};
        setting[1] = '{16'd65535, 16'd1, 16'd0};
        setting[2] = '{mcdt_pkg::period_t'($urandom()), mcdt_pkg::period_t'($urandom()),
                       mcdt_pkg::period_t'($urandom())};
        setting[3] = '{16'd250, 16'd1000, 16'd3000};
        setting[4] = '{16'd1, 16'd1, 16'd1};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words at reset periods (1000 ms)
        send_word(mk(mcdt_pkg::CMD_UPDATE, 0, 0, 0, 0));         // every deadline equals now
        send_word(mk(mcdt_pkg::CMD_UPDATE, 1, 0, 0, 0));         // periodic catch-up from zero
        send_word(mk(mcdt_pkg::CMD_UPDATE, 1000000, 0, 0, 0));   // deadline equal now: not past
        send_word(mk(mcdt_pkg::CMD_ARM, 1000000, 3, 0, 0));      // arm, zero delay
        send_word(mk(mcdt_pkg::CMD_ARM, 1000000, 3, 16'hFFFF, 0)); // already armed: ignored
        send_word(mk(mcdt_pkg::CMD_ARM, 1000000, 0, 10, 0));     // arm of a periodic channel
        send_word(mk(mcdt_pkg::CMD_DISARM, 1000000, 1, 0, 0));   // disarm of a periodic channel
        send_word(mk(mcdt_pkg::CMD_ARM, 1000500, 8, 16'hFFFF, '1)); // longest delay, last ch
        send_word(mk(mcdt_pkg::CMD_DISARM, 1000600, 3, 0, 0));
        send_word(mk(mcdt_pkg::CMD_LOAD, 1000700, 5, 0, 1000699)); // load in the past fires
        send_word(mk(mcdt_pkg::CMD_LOAD, 1000800, 15, '1, 0));   // channel out of range
        send_word(mk(mcdt_pkg::CMD_ARM, 1000800, 9, 100, 0));    // channel out of range
        // push all periodic deadlines far out; the wait saturates at the next update
        send_word(mk(mcdt_pkg::CMD_LOAD, 1000900, 0, 0, 48'h4000_0000_0000));
        send_word(mk(mcdt_pkg::CMD_LOAD, 1000900, 1, 0, 48'h4000_0000_0000));
        send_word(mk(mcdt_pkg::CMD_LOAD, 1000900, 2, 0, 48'h4000_0000_0000));
        send_word(mk(mcdt_pkg::CMD_UPDATE, '1, 0, 0, 0));        // largest now, wraps the compare
        send_word(mk(mcdt_pkg::CMD_LOAD, '1, 6, 0, 10));         // deadline past the wrap
        send_word(mk(mcdt_pkg::CMD_UPDATE, 20, 0, 0, 0));        // time wraps and ch6 expires
        send_word(mk(mcdt_pkg::CMD_LOAD, 20, 0, 0, 0));          // periodic load in the past
        send_word(mk(mcdt_pkg::CMD_UPDATE, 2000000, 15, '1, '1)); // catch-up lands on now
        send_word(mk(mcdt_pkg::CMD_ARM, 2000000, 4, 1, 0));
        send_word(mk(mcdt_pkg::CMD_UPDATE, 2000999, 0, 0, 0));
        send_word(mk(mcdt_pkg::CMD_UPDATE, 2001001, 0, 0, 0));   // ch4 just expired
        send_word(mk(mcdt_pkg::CMD_LOAD, 2001001, 1, 0, 2001001)); // ch1 and ch2 back near now
        send_word(mk(mcdt_pkg::CMD_LOAD, 2001001, 2, 0, 2001001));
        clock_us = 48'd2001001;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // registers change only with the block idle
            settle();
            for (int r = 0; r < mcdt_pkg::NUM_REGS; r++)
                write_reg(mcdt_pkg::REG_IDX_W'(r), setting[ph][r]);
            if (ph == 2)
                write_reg(mcdt_pkg::REG_IDX_W'(mcdt_pkg::NUM_REGS),
                          mcdt_pkg::period_t'($urandom()));  // dropped
            steady = (ph == 3);
            run_phase(WORDS_PER_PHASE, ph == 1);
            steady = 1'b0;
        end

        settle();
        if (tracker.due_q.size() != 0)
            tracker.flag_mismatch($sformatf("%0d results never arrived", tracker.due_q.size()));

        $display("ran %0d command words over %0d period settings", tracker.words,
                 NUM_PHASES + 1);
        $display("periodic catch-ups %0d, one-shot expiries %0d, saturated waits %0d",
                 tracker.catchups, tracker.expiries, tracker.saturated);
        if (tracker.mismatches == 0) begin
            $display("[multi_channel_deadline_timer_core] OK");
        end else begin
            $display("[multi_channel_deadline_timer_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mcdt_pkg.sv
rtl/mcdt_fifo.sv
rtl/mcdt_front.sv
rtl/mcdt_rem.sv
rtl/mcdt_back.sv
rtl/multi_channel_deadline_timer_core.sv
verif/tb_multi_channel_deadline_timer_core.sv
